### sv/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge out of reset.
`define CSVT_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define CSVT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CSVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/csvt_pkg.sv
// Types and constants of the CSV field tokenizer.
`timescale 1ns / 1ps

package csvt_pkg;

    localparam int RES_MAX = 3;

    localparam logic [7:0] DELIM_RESET  = 8'h2C;
    localparam logic [7:0] QUOTE_RESET  = 8'h22;
    localparam logic [7:0] ESCAPE_RESET = 8'h5C;
    localparam logic [7:0] SPACE_BYTE   = 8'h20;
    localparam logic [7:0] ESC_N_BYTE   = 8'h6E;
    localparam logic [7:0] ESC_R_BYTE   = 8'h72;
    localparam logic [7:0] LF_BYTE      = 8'h0A;
    localparam logic [7:0] CR_BYTE      = 8'h0D;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_DELIMITER = 2'd0;
    localparam cfg_index_t CFG_QUOTE     = 2'd1;
    localparam cfg_index_t CFG_ESCAPE    = 2'd2;

    typedef enum logic [2:0] {
        MODE_OUTSIDE  = 3'd0,
        MODE_UNQUOTED = 3'd1,
        MODE_QUOTED   = 3'd2,
        MODE_ESCAPED  = 3'd3,
        MODE_QPENDING = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_END     = 2'd1,
        KIND_DISCARD = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] delimiter_char;
        logic [7:0] quote_char;
        logic [7:0] escape_char;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       line_end;
    } result_t;

    typedef result_t [RES_MAX-1:0] res_set_t;
    typedef logic [1:0] res_cnt_t;

endpackage

### sv/csvt_in_if.sv
// Byte input channel of the tokenizer.
`timescale 1ns / 1ps

interface csvt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       line_last;

    modport source (output valid, output in_byte, output line_last, input ready);
    modport sink   (input valid, input in_byte, input line_last, output ready);
endinterface

### sv/csvt_out_if.sv
// Token output channel of the tokenizer.
`timescale 1ns / 1ps

interface csvt_out_if;
    logic              valid;
    logic              ready;
    csvt_pkg::kind_t   kind;
    logic [7:0]        data_byte;
    logic              line_end;
    logic              run_last;

    modport source (output valid, output kind, output data_byte, output line_end,
                    output run_last, input ready);
    modport sink   (input valid, input kind, input data_byte, input line_end,
                    input run_last, output ready);
endinterface

### sv/csvt_cfg_if.sv
// Configuration write channel of the tokenizer.
`timescale 1ns / 1ps

interface csvt_cfg_if;
    logic                   valid;
    logic                   ready;
    csvt_pkg::cfg_index_t   index;
    logic [7:0]             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/csvt_parse.sv
// Per-byte parse step: next mode and up to three results for one byte.
`timescale 1ns / 1ps

module csvt_parse (
    input  csvt_pkg::mode_t    mode,
    input  logic [7:0]         in_byte,
    input  logic               line_last,
    input  csvt_pkg::cfg_t     cfg,
    output csvt_pkg::mode_t    mode_next,
    output csvt_pkg::res_set_t res,
    output csvt_pkg::res_cnt_t res_cnt
);
    import csvt_pkg::*;

    mode_t    body_mode;
    res_cnt_t body_cnt;
    mode_t    out_mode;
    logic     out_hit;
    result_t  out_res;
    result_t  data_res;
    result_t  end_res;
    result_t  quote_res;

    assign data_res  = '{kind: KIND_DATA, data_byte: in_byte, line_end: 1'b0};
    assign end_res   = '{kind: KIND_END, data_byte: 8'h00, line_end: 1'b0};
    assign quote_res = '{kind: KIND_DATA, data_byte: cfg.quote_char, line_end: 1'b0};

    // outside a field
    always_comb
    begin
        out_mode = MODE_OUTSIDE;
        out_hit  = 1'b0;
        out_res  = end_res;
        if (in_byte == cfg.delimiter_char)
        begin
            out_hit = 1'b1;
        end
        else if (in_byte == cfg.quote_char)
        begin
            out_mode = MODE_QUOTED;
        end
        else if (in_byte != SPACE_BYTE)
        begin
            out_mode = MODE_UNQUOTED;
            out_hit  = 1'b1;
            out_res  = data_res;
        end
    end

    always_comb
    begin
        res       = '0;
        body_cnt  = 2'd0;
        body_mode = mode;
        unique case (mode)
            MODE_UNQUOTED:
            begin
                body_cnt = 2'd1;
                if (in_byte == cfg.delimiter_char)
                begin
                    res[0]    = end_res;
                    body_mode = MODE_OUTSIDE;
                end
                else
                begin
                    res[0] = data_res;
                end
            end
            MODE_QUOTED:
            begin
                if (in_byte == cfg.escape_char)
                begin
                    body_mode = MODE_ESCAPED;
                end
                else if (in_byte == cfg.quote_char)
                begin
                    body_mode = line_last ? MODE_OUTSIDE : MODE_QPENDING;
                end
                else
                begin
                    res[0]   = data_res;
                    body_cnt = 2'd1;
                end
            end
            MODE_ESCAPED:
            begin
                body_mode = MODE_QUOTED;
                body_cnt  = 2'd1;
                res[0]    = data_res;
                if (in_byte == cfg.escape_char)
                begin
                    res[0].data_byte = cfg.escape_char;
                end
                else if (in_byte == cfg.quote_char)
                begin
                    res[0].data_byte = cfg.quote_char;
                end
                else if (in_byte == ESC_N_BYTE)
                begin
                    res[0].data_byte = LF_BYTE;
                end
                else if (in_byte == ESC_R_BYTE)
                begin
                    res[0].data_byte = CR_BYTE;
                end
                else
                begin
                    body_cnt = 2'd0;
                end
            end
            MODE_QPENDING:
            begin
                if (in_byte == cfg.quote_char)
                begin
                    res[0]    = quote_res;
                    res[1]    = quote_res;
                    body_cnt  = 2'd2;
                    body_mode = MODE_QUOTED;
                end
                else
                begin
                    body_mode = out_mode;
                    res[0]    = out_res;
                    body_cnt  = {1'b0, out_hit};
                end
            end
            default:
            begin
                body_mode = out_mode;
                res[0]    = out_res;
                body_cnt  = {1'b0, out_hit};
            end
        endcase

        mode_next = body_mode;
        res_cnt   = body_cnt;
        if (line_last)
        begin
            res[body_cnt].line_end  = 1'b1;
            res[body_cnt].data_byte = 8'h00;
            if (body_mode == MODE_QUOTED || body_mode == MODE_ESCAPED ||
                body_mode == MODE_QPENDING)
            begin
                res[body_cnt].kind = KIND_DISCARD;
            end
            else
            begin
                res[body_cnt].kind = KIND_END;
            end
            res_cnt   = body_cnt + 2'd1;
            mode_next = MODE_OUTSIDE;
        end
    end

endmodule

### sv/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer with backslash escapes.
//
// Channels: byte_in takes one byte of a text line per transfer, with line_last
// set on the final byte of the line. token_out gives field data bytes, field
// ends and discard marks, run_last set on the last token caused by a byte.
// cfg writes delimiter_char (index 0), quote_char (1) and escape_char (2);
// it is always ready and should be used only while the block is idle.
// The first token of a byte comes from the token register, which one parse
// step loads from the input register once the token register is free.
// Throughput: one byte per cycle while each byte yields at most one token and
// the receiver is ready; a byte with more tokens holds the token register until all are taken.
// The input register keeps taking one byte while a token waits, so a stalled
// receiver halts input only once that register is full; nothing is lost.
// Reset: parse state returns to outside a field, both registers empty, the
// configuration registers take comma, double quote and backslash.
`timescale 1ns / 1ps

module csv_field_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    csvt_in_if.sink     byte_in,
    csvt_out_if.source  token_out,
    csvt_cfg_if.sink    cfg
);
    import csvt_pkg::*;

`include "assert_macros.svh"

    cfg_t     cfg_reg;
    mode_t    mode_reg;
    mode_t    mode_next;
    logic     in_valid_reg;
    logic     in_valid_next;
    logic [7:0] in_byte_reg;
    logic     in_last_reg;
    logic     bnd_valid_reg;
    logic     bnd_valid_next;
    res_set_t res_reg;
    res_cnt_t cnt_reg;
    res_cnt_t idx_reg;
    res_cnt_t idx_next;
    res_set_t parse_res;
    res_cnt_t parse_cnt;
    logic     in_xfer;
    logic     out_xfer;
    logic     at_last;
    logic     bnd_free;
    logic     load;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{delimiter_char: DELIM_RESET, quote_char: QUOTE_RESET,
                         escape_char: ESCAPE_RESET};
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DELIMITER: cfg_reg.delimiter_char <= cfg.data;
                CFG_QUOTE:     cfg_reg.quote_char     <= cfg.data;
                CFG_ESCAPE:    cfg_reg.escape_char    <= cfg.data;
                default:       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    csvt_parse u_parse (
        .mode      (mode_reg),
        .in_byte   (in_byte_reg),
        .line_last (in_last_reg),
        .cfg       (cfg_reg),
        .mode_next (mode_next),
        .res       (parse_res),
        .res_cnt   (parse_cnt)
    );

    assign out_xfer      = token_out.valid && token_out.ready;
    assign at_last       = (idx_reg == cnt_reg - 2'd1);
    assign bnd_free      = !bnd_valid_reg || (token_out.ready && at_last);
    assign load          = in_valid_reg && bnd_free;
    assign byte_in.ready = !in_valid_reg || load;
    assign in_xfer       = byte_in.valid && byte_in.ready;
    assign in_valid_next = in_xfer || (in_valid_reg && !load);

    always_comb
    begin
        bnd_valid_next = bnd_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            bnd_valid_next = (parse_cnt != 2'd0);
            idx_next       = 2'd0;
        end
        else if (out_xfer)
        begin
            if (at_last)
            begin
                bnd_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            bnd_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            cnt_reg       <= 2'd0;
            mode_reg      <= MODE_OUTSIDE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            bnd_valid_reg <= bnd_valid_next;
            idx_reg       <= idx_next;
            if (load)
            begin
                mode_reg <= mode_next;
                cnt_reg  <= parse_cnt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= byte_in.in_byte;
            in_last_reg <= byte_in.line_last;
        end
        if (load)
        begin
            res_reg <= parse_res;
        end
    end

    assign token_out.valid     = bnd_valid_reg;
    assign token_out.kind      = res_reg[idx_reg].kind;
    assign token_out.data_byte = res_reg[idx_reg].data_byte;
    assign token_out.line_end  = res_reg[idx_reg].line_end;
    assign token_out.run_last  = at_last;

    `CSVT_ASSERT_IMPLY(a_idx_in_range, bnd_valid_reg, idx_reg < cnt_reg, "token index past count")
    `CSVT_ASSERT_IMPLY(a_cnt_nonzero, bnd_valid_reg, cnt_reg != 2'd0, "empty token group held")
    `CSVT_ASSERT_NEXT(a_line_resets_mode, load && in_last_reg, mode_reg == MODE_OUTSIDE, "mode not reset at line end")
    `CSVT_ASSERT_IMPLY(a_line_end_closes, token_out.valid && token_out.line_end, token_out.run_last, "line end not last token of byte")
    `CSVT_ASSERT_NEXT(a_stall_holds_idx, bnd_valid_reg && !token_out.ready, $stable(idx_reg), "token index moved under stall")

endmodule
